// ===== design/nscp_pkg.sv =====
package nscp_pkg;

	// default sizes
	localparam int SLOTS_DEF      = 1024;
	localparam int NEST_DEPTH_DEF = 32;

	// field widths
	localparam int ACT_W  = 2;
	localparam int SLOT_W = 10;
	localparam int TS_W   = 64;
	localparam int STS_W  = 2;
	localparam int SUM_W  = 64;
	localparam int HIT_W  = 32;

	// event codes
	localparam logic [ACT_W-1:0] ACT_ENTER = 2'd0;
	localparam logic [ACT_W-1:0] ACT_EXIT  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

	// status codes
	localparam logic [STS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STS_W-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [STS_W-1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [STS_W-1:0] ST_BAD_SLOT  = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic capture;
		logic lookup;
		logic commit;
		logic load_out;
	} nscp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic exit_go;
	} nscp_sts_t;

endpackage

// ===== design/nscp_ctrl.sv =====
module nscp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output nscp_pkg::nscp_cmd_t cmd,
	input  nscp_pkg::nscp_sts_t sts
);
	import nscp_pkg::*;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_LOOKUP = 3'd2;
	localparam logic [2:0] S_COMMIT = 3'd3;
	localparam logic [2:0] S_RESP   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = sts.exit_go ? S_COMMIT : S_RESP;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== design/nscp_dp.sv =====
module nscp_dp #(
	parameter int SLOTS      = nscp_pkg::SLOTS_DEF,
	parameter int NEST_DEPTH = nscp_pkg::NEST_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  nscp_pkg::nscp_cmd_t           cmd,
	output nscp_pkg::nscp_sts_t           sts,
	input  logic [nscp_pkg::ACT_W-1:0]    in_action,
	input  logic [nscp_pkg::SLOT_W-1:0]   in_slot,
	input  logic [nscp_pkg::TS_W-1:0]     in_timestamp,
	output logic [nscp_pkg::STS_W-1:0]    out_status,
	output logic [nscp_pkg::SUM_W-1:0]    out_elapsed_sum,
	output logic [nscp_pkg::SUM_W-1:0]    out_children_sum,
	output logic [nscp_pkg::SUM_W-1:0]    out_outer_inclusive_sum,
	output logic [nscp_pkg::SUM_W-1:0]    out_self_cycles,
	output logic [nscp_pkg::HIT_W-1:0]    out_hit_count,
	output logic [nscp_pkg::SLOT_W-1:0]   out_highest_slot,
	output logic [nscp_pkg::SLOT_W-1:0]   out_active_slot
);
	import nscp_pkg::*;

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int DW = $clog2(NEST_DEPTH + 1);
	localparam int AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

	// tables and stack
	logic [SUM_W-1:0]  el_mem    [SLOTS];
	logic [SUM_W-1:0]  ch_mem    [SLOTS];
	logic [SUM_W-1:0]  in_mem    [SLOTS];
	logic [HIT_W-1:0]  hit_mem   [SLOTS];
	logic [SLOT_W-1:0] stk_slot  [NEST_DEPTH];
	logic [TS_W-1:0]   stk_start [NEST_DEPTH];
	logic [SUM_W-1:0]  stk_saved [NEST_DEPTH];

	// registered read data
	logic [SUM_W-1:0]  el_rd_q, ch_rd_q, in_rd_q;
	logic [HIT_W-1:0]  hit_rd_q;
	logic [SLOT_W-1:0] par_rd_q;
	logic [TS_W-1:0]   start_rd_q;
	logic [SUM_W-1:0]  saved_rd_q;

	// control state
	logic [DW-1:0]     depth_q;
	logic [SLOT_W-1:0] max_q;
	logic [SLOT_W-1:0] top_slot_q;
	logic [SW-1:0]     clr_q;

	// event registers
	logic [ACT_W-1:0]  act_q;
	logic [SLOT_W-1:0] slot_q;
	logic [TS_W-1:0]   ts_q;
	logic [TS_W-1:0]   diff_q;

	// held result
	logic [STS_W-1:0]  res_status_q;
	logic [SUM_W-1:0]  res_el_q, res_ch_q, res_in_q, res_self_q;
	logic [HIT_W-1:0]  res_hit_q;

	logic              slot_ok, full, empty, has_parent;
	logic              enter_go, read_go;
	logic [STS_W-1:0]  status_c;
	logic [SW-1:0]     rd_idx, slot_idx, top_idx, par_idx;
	logic              ch_re;

	// table write ports
	logic              el_we, ch_we, in_we, hit_we;
	logic [SW-1:0]     el_wa, ch_wa, in_wa, hit_wa;
	logic [SUM_W-1:0]  el_wd, ch_wd, in_wd;
	logic [HIT_W-1:0]  hit_wd;
	logic [SW-1:0]     ch_ra;
	logic              stk_we;

	assign slot_ok    = (slot_q != '0) && (32'(slot_q) < 32'(SLOTS));
	assign full       = (depth_q == DW'(NEST_DEPTH));
	assign empty      = (depth_q == '0);
	assign has_parent = (depth_q > DW'(1));
	assign slot_idx   = SW'(slot_q);
	assign top_idx    = SW'(top_slot_q);
	assign par_idx    = SW'(par_rd_q);

	assign enter_go    = (act_q == ACT_ENTER) && slot_ok && !full;
	assign read_go     = (act_q == ACT_READ) && slot_ok;
	assign sts.exit_go = (act_q == ACT_EXIT) && !empty;
	assign sts.clear_last = (clr_q == SW'(SLOTS - 1));

	always_comb begin
		status_c = ST_OK;
		case (act_q)
			ACT_ENTER: begin
				if (!slot_ok) status_c = ST_BAD_SLOT;
				else if (full) status_c = ST_OVERFLOW;
			end
			ACT_EXIT: begin
				if (empty) status_c = ST_UNDERFLOW;
			end
			ACT_READ: begin
				if (!slot_ok) status_c = ST_BAD_SLOT;
			end
			default: begin
				status_c = ST_OK;
			end
		endcase
	end

	// an exit looks up the innermost slot, everything else the given slot
	assign rd_idx = (in_action == ACT_EXIT) ? top_idx : SW'(in_slot);
	assign ch_re  = cmd.capture || (cmd.lookup && sts.exit_go);
	assign ch_ra  = cmd.capture ? rd_idx : par_idx;

	always_comb begin
		el_we  = cmd.clear || cmd.commit;
		el_wa  = cmd.clear ? clr_q : top_idx;
		el_wd  = cmd.clear ? '0 : el_rd_q + diff_q;
		in_we  = cmd.clear || cmd.commit;
		in_wa  = cmd.clear ? clr_q : top_idx;
		in_wd  = cmd.clear ? '0 : saved_rd_q + diff_q;
		ch_we  = cmd.clear || (cmd.commit && has_parent);
		ch_wa  = cmd.clear ? clr_q : par_idx;
		ch_wd  = cmd.clear ? '0 : ch_rd_q + diff_q;
		hit_we = cmd.clear || (cmd.lookup && enter_go);
		hit_wa = cmd.clear ? clr_q : slot_idx;
		hit_wd = cmd.clear ? '0 : hit_rd_q + HIT_W'(1);
		stk_we = cmd.lookup && enter_go;
	end

	always_ff @(posedge clk) begin
		if (el_we) el_mem[el_wa] <= el_wd;
		if (cmd.capture) el_rd_q <= el_mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (ch_we) ch_mem[ch_wa] <= ch_wd;
		if (ch_re) ch_rd_q <= ch_mem[ch_ra];
	end

	always_ff @(posedge clk) begin
		if (in_we) in_mem[in_wa] <= in_wd;
		if (cmd.capture) in_rd_q <= in_mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (hit_we) hit_mem[hit_wa] <= hit_wd;
		if (cmd.capture) hit_rd_q <= hit_mem[rd_idx];
	end

	// stack: push at depth, top at depth-1, parent at depth-2
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_slot[AW'(depth_q)]  <= slot_q;
			stk_start[AW'(depth_q)] <= ts_q;
			stk_saved[AW'(depth_q)] <= in_rd_q;
		end
		if (cmd.capture) begin
			par_rd_q   <= stk_slot[AW'(depth_q - DW'(2))];
			start_rd_q <= stk_start[AW'(depth_q - DW'(1))];
			saved_rd_q <= stk_saved[AW'(depth_q - DW'(1))];
		end
	end

	// event and result registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q  <= in_action;
			slot_q <= in_slot;
			ts_q   <= in_timestamp;
		end
		if (cmd.lookup) begin
			diff_q       <= ts_q - start_rd_q;
			res_status_q <= status_c;
			res_el_q     <= read_go ? el_rd_q : '0;
			res_ch_q     <= read_go ? ch_rd_q : '0;
			res_in_q     <= read_go ? in_rd_q : '0;
			res_self_q   <= read_go ? (el_rd_q - ch_rd_q) : '0;
			res_hit_q    <= read_go ? hit_rd_q : '0;
		end
		if (cmd.load_out) begin
			out_status              <= res_status_q;
			out_elapsed_sum         <= res_el_q;
			out_children_sum        <= res_ch_q;
			out_outer_inclusive_sum <= res_in_q;
			out_self_cycles         <= res_self_q;
			out_hit_count           <= res_hit_q;
			out_highest_slot        <= max_q;
			out_active_slot         <= top_slot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q    <= '0;
			max_q      <= '0;
			top_slot_q <= '0;
			clr_q      <= '0;
		end else begin
			if (cmd.clear) clr_q <= clr_q + SW'(1);
			if (cmd.lookup && enter_go) begin
				depth_q    <= depth_q + DW'(1);
				top_slot_q <= slot_q;
				if (slot_q > max_q) max_q <= slot_q;
			end
			if (cmd.commit) begin
				depth_q    <= depth_q - DW'(1);
				top_slot_q <= has_parent ? par_rd_q : '0;
			end
		end
	end

endmodule

// ===== design/nested_scope_cycle_profiler.sv =====
// nested scope cycle profiler: per-slot cycle sums over a stack of open scopes
// sequence: capture, lookup, write-back (exit only), result handoff, set by the sequencer
//   stepping through registered table and stack reads, then the writes; one event at a time,
//   the next is taken only after the result has moved into the output register
// reset: arst_n asynchronous, active low; afterwards a clearing pass
//   zeroes the slot tables, one entry a cycle, before the first event is taken
module nested_scope_cycle_profiler #(
	parameter int SLOTS      = nscp_pkg::SLOTS_DEF,
	parameter int NEST_DEPTH = nscp_pkg::NEST_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// event side
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [79:0]  s_axis_tdata,  // action[1:0], slot[11:2], timestamp[75:12], zero fill
	// result side
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [311:0] m_axis_tdata   // status[1:0], elapsed_sum[65:2], children_sum[129:66],
	                                    // outer_inclusive_sum[193:130], self_cycles[257:194],
	                                    // hit_count[289:258], highest_slot[299:290],
	                                    // active_slot[309:300], zero fill
);
	import nscp_pkg::*;

	nscp_cmd_t cmd;
	nscp_sts_t sts;

	logic [STS_W-1:0]  status;
	logic [SUM_W-1:0]  elapsed_sum, children_sum, outer_inclusive_sum, self_cycles;
	logic [HIT_W-1:0]  hit_count;
	logic [SLOT_W-1:0] highest_slot, active_slot;

	// sequencer: clearing pass, event capture, lookup, write-back, result handoff
	nscp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// tables, scope stack and the held result
	nscp_dp #(
		.SLOTS      (SLOTS),
		.NEST_DEPTH (NEST_DEPTH)
	) u_dp (
		.clk                     (clk),
		.arst_n                  (arst_n),
		.cmd                     (cmd),
		.sts                     (sts),
		.in_action               (s_axis_tdata[1:0]),
		.in_slot                 (s_axis_tdata[11:2]),
		.in_timestamp            (s_axis_tdata[75:12]),
		.out_status              (status),
		.out_elapsed_sum         (elapsed_sum),
		.out_children_sum        (children_sum),
		.out_outer_inclusive_sum (outer_inclusive_sum),
		.out_self_cycles         (self_cycles),
		.out_hit_count           (hit_count),
		.out_highest_slot        (highest_slot),
		.out_active_slot         (active_slot)
	);

	// result packing, lowest field first
	assign m_axis_tdata = {2'b00, active_slot, highest_slot, hit_count, self_cycles,
	                       outer_inclusive_sum, children_sum, elapsed_sum, status};

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import nscp_pkg::*;

	// the unused action code, which the block must answer with a plain ok
	localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
	localparam int DIR_N  = 22;
	localparam int RAND_N = 520;
	localparam int QUIET_N = 100;

	typedef struct packed {
		logic [STS_W-1:0]  status;
		logic [SUM_W-1:0]  elapsed;
		logic [SUM_W-1:0]  children;
		logic [SUM_W-1:0]  inclusive;
		logic [SUM_W-1:0]  self_cyc;
		logic [HIT_W-1:0]  hits;
		logic [SLOT_W-1:0] highest;
		logic [SLOT_W-1:0] active;
	} report_t;

	typedef struct packed {
		logic [ACT_W-1:0]  act;
		logic [SLOT_W-1:0] slot;
		logic [TS_W-1:0]   ts;
		logic              lit;
		report_t           want;
	} stim_row_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [79:0]  s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [311:0] m_axis_tdata;

	// predicted profiler state
	logic [SUM_W-1:0]  elapsed_tab   [SLOTS_DEF];
	logic [SUM_W-1:0]  children_tab  [SLOTS_DEF];
	logic [SUM_W-1:0]  inclusive_tab [SLOTS_DEF];
	logic [HIT_W-1:0]  hits_tab      [SLOTS_DEF];
	logic [SLOT_W-1:0] slot_stk      [NEST_DEPTH_DEF];
	logic [TS_W-1:0]   start_stk     [NEST_DEPTH_DEF];
	logic [SUM_W-1:0]  saved_stk     [NEST_DEPTH_DEF];
	int                open_depth;
	logic [SLOT_W-1:0] top_slot_seen;

	report_t   report_q [$];
	stim_row_t dir_tab [DIR_N];
	int        mismatch_cnt = 0;
	bit        gaps_on = 1'b1;
	bit        long_hold_req = 1'b0;
	int        hold_left = 0;

	nested_scope_cycle_profiler uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #1 clk = ~clk;

	// report with all counter fields zero
	function automatic report_t mk_rep(logic [STS_W-1:0] st, logic [SLOT_W-1:0] hi,
		logic [SLOT_W-1:0] act_slot);
		report_t r;
		r = '0;
		r.status  = st;
		r.highest = hi;
		r.active  = act_slot;
		return r;
	endfunction

	// one event through the predicted profiler
	task automatic profile_event(input logic [ACT_W-1:0] act, input logic [SLOT_W-1:0] slot,
		input logic [TS_W-1:0] ts, output report_t r);
		logic [SUM_W-1:0] span;
		int top;
		r = '0;
		r.status = ST_OK;
		case (act)
			ACT_ENTER: begin
				if (slot == '0 || int'(slot) >= SLOTS_DEF) begin
					r.status = ST_BAD_SLOT;
				end else if (open_depth >= NEST_DEPTH_DEF) begin
					r.status = ST_OVERFLOW;
				end else begin
					slot_stk[open_depth]  = slot;
					start_stk[open_depth] = ts;
					saved_stk[open_depth] = inclusive_tab[slot];
					open_depth++;
					hits_tab[slot] = hits_tab[slot] + 1'b1;
					if (slot > top_slot_seen) top_slot_seen = slot;
				end
			end
			ACT_EXIT: begin
				if (open_depth == 0) begin
					r.status = ST_UNDERFLOW;
				end else begin
					top  = open_depth - 1;
					span = ts - start_stk[top];
					elapsed_tab[slot_stk[top]]   = elapsed_tab[slot_stk[top]] + span;
					inclusive_tab[slot_stk[top]] = saved_stk[top] + span;
					// outermost scope has no parent to charge
					if (top > 0)
						children_tab[slot_stk[top-1]] = children_tab[slot_stk[top-1]] + span;
					open_depth = top;
				end
			end
			ACT_READ: begin
				if (slot == '0 || int'(slot) >= SLOTS_DEF) begin
					r.status = ST_BAD_SLOT;
				end else begin
					r.elapsed   = elapsed_tab[slot];
					r.children  = children_tab[slot];
					r.inclusive = inclusive_tab[slot];
					r.self_cyc  = elapsed_tab[slot] - children_tab[slot];
					r.hits      = hits_tab[slot];
				end
			end
			default: ;
		endcase
		r.highest = top_slot_seen;
		r.active  = (open_depth > 0) ? slot_stk[open_depth-1] : '0;
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatch_cnt++;
		end
	endtask

	// offer one event transaction, with an optional gap first
	task automatic offer_event(input logic [ACT_W-1:0] act, input logic [SLOT_W-1:0] slot,
		input logic [TS_W-1:0] ts, input logic lit, input report_t want);
		report_t pred;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'd0, ts, slot, act};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		profile_event(act, slot, ts, pred);
		report_q.push_back(lit ? want : pred);
	endtask

	// result side: check accepted transactions, stall in bursts or on request
	initial begin
		report_t want;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				if (report_q.size() == 0) begin
					$display("%0t: result with no expectation, actual %h", $time, m_axis_tdata);
					mismatch_cnt++;
				end else begin
					want = report_q.pop_front();
					check_field("status",      64'(want.status),    64'(m_axis_tdata[1:0]));
					check_field("elapsed_sum", want.elapsed,        m_axis_tdata[65:2]);
					check_field("children_sum", want.children,      m_axis_tdata[129:66]);
					check_field("outer_inclusive_sum", want.inclusive, m_axis_tdata[193:130]);
					check_field("self_cycles", want.self_cyc,       m_axis_tdata[257:194]);
					check_field("hit_count",   64'(want.hits),      64'(m_axis_tdata[289:258]));
					check_field("highest_slot", 64'(want.highest),  64'(m_axis_tdata[299:290]));
					check_field("active_slot", 64'(want.active),    64'(m_axis_tdata[309:300]));
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (long_hold_req) begin
				// long hold-off so the block backs up into its input
				long_hold_req = 1'b0;
				hold_left = 299;
				m_axis_tready <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 7) == 0) begin
				hold_left = $urandom_range(0, 16);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog
	initial begin
		#400000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic [TS_W-1:0]   now;
		logic [ACT_W-1:0]  act;
		logic [SLOT_W-1:0] slot;
		int roll;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		for (int k = 0; k < SLOTS_DEF; k++) begin
			elapsed_tab[k]   = '0;
			children_tab[k]  = '0;
			inclusive_tab[k] = '0;
			hits_tab[k]      = '0;
		end
		open_depth    = 0;
		top_slot_seen = '0;

		// directed rows: literal expectations where obvious, predictor elsewhere
		dir_tab[0]  = '{ACT_READ,  10'd1,    64'd0, 1'b1, mk_rep(ST_OK, 10'd0, 10'd0)};
		dir_tab[1]  = '{ACT_EXIT,  10'd0,    64'd5, 1'b1, mk_rep(ST_UNDERFLOW, 10'd0, 10'd0)};
		dir_tab[2]  = '{ACT_ENTER, 10'd0,    64'd6, 1'b1, mk_rep(ST_BAD_SLOT, 10'd0, 10'd0)};
		dir_tab[3]  = '{ACT_READ,  10'd0,    64'd7, 1'b1, mk_rep(ST_BAD_SLOT, 10'd0, 10'd0)};
		dir_tab[4]  = '{ACT_SPARE, 10'd5,    64'd8, 1'b1, mk_rep(ST_OK, 10'd0, 10'd0)};
		dir_tab[5]  = '{ACT_ENTER, 10'd1023, 64'hFFFF_FFFF_FFFF_FFF0, 1'b1,
			mk_rep(ST_OK, 10'd1023, 10'd1023)};
		dir_tab[6]  = '{ACT_ENTER, 10'd1,    64'h10, 1'b1, mk_rep(ST_OK, 10'd1023, 10'd1)};
		// recursion into the same slot
		dir_tab[7]  = '{ACT_ENTER, 10'd1,    64'h20, 1'b1, mk_rep(ST_OK, 10'd1023, 10'd1)};
		dir_tab[8]  = '{ACT_READ,  10'd1,    64'h21, 1'b0, report_t'('0)};
		dir_tab[9]  = '{ACT_EXIT,  10'd0,    64'h30, 1'b0, report_t'('0)};
		dir_tab[10] = '{ACT_EXIT,  10'd0,    64'h40, 1'b0, report_t'('0)};
		dir_tab[11] = '{ACT_READ,  10'd1,    64'h41, 1'b0, report_t'('0)};
		// outermost exit, time wraps past zero
		dir_tab[12] = '{ACT_EXIT,  10'd0,    64'd0, 1'b0, report_t'('0)};
		dir_tab[13] = '{ACT_READ,  10'd1023, 64'd1, 1'b0, report_t'('0)};
		dir_tab[14] = '{ACT_EXIT,  10'h3FF,  64'd2, 1'b1, mk_rep(ST_UNDERFLOW, 10'd1023, 10'd0)};
		dir_tab[15] = '{ACT_ENTER, 10'd512,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
			mk_rep(ST_OK, 10'd1023, 10'd512)};
		dir_tab[16] = '{ACT_ENTER, 10'd2,    64'd5, 1'b1, mk_rep(ST_OK, 10'd1023, 10'd2)};
		dir_tab[17] = '{ACT_EXIT,  10'd0,    64'd7, 1'b0, report_t'('0)};
		dir_tab[18] = '{ACT_EXIT,  10'd0,    64'd0, 1'b0, report_t'('0)};
		dir_tab[19] = '{ACT_READ,  10'd512,  64'd9, 1'b0, report_t'('0)};
		dir_tab[20] = '{ACT_READ,  10'd2,    64'd9, 1'b0, report_t'('0)};
		dir_tab[21] = '{ACT_READ,  10'd1023, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, report_t'('0)};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int k = 0; k < DIR_N; k++)
			offer_event(dir_tab[k].act, dir_tab[k].slot, dir_tab[k].ts, dir_tab[k].lit,
				dir_tab[k].want);

		// sender pause until the block has drained
		s_axis_tvalid <= 1'b0;
		while (report_q.size() != 0) @(posedge clk);

		// deep dive: fill the stack, overflow once, unwind and underflow once,
		// with the result side held off at the start
		now = {$urandom, $urandom};
		long_hold_req = 1'b1;
		repeat (NEST_DEPTH_DEF + 1) begin
			now += 64'($urandom_range(0, 50));
			offer_event(ACT_ENTER, 10'($urandom_range(1, SLOTS_DEF - 1)), now, 1'b0, '0);
		end
		offer_event(ACT_READ, 10'($urandom_range(1, 8)), now, 1'b0, '0);
		repeat (NEST_DEPTH_DEF + 1) begin
			now += 64'($urandom_range(0, 50));
			offer_event(ACT_EXIT, 10'($urandom), now, 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;
		while (report_q.size() != 0) @(posedge clk);

		// random nesting with mostly well-formed enter and exit pairs
		for (int i = 0; i < RAND_N; i++) begin
			if (i == RAND_N - QUIET_N) gaps_on = 1'b0;
			roll = $urandom_range(0, 99);
			slot = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(1, SLOTS_DEF - 1))
				: 10'($urandom_range(1, 8));
			now += 64'($urandom_range(0, 2000));
			if ($urandom_range(0, 49) == 0) now = {$urandom, $urandom};
			if (roll < 4) begin
				act  = ACT_SPARE;
				slot = 10'($urandom);
			end else if (roll < 8) begin
				act  = ($urandom_range(0, 1) == 0) ? ACT_ENTER : ACT_READ;
				slot = '0;
			end else if (roll < 28) begin
				act = ACT_READ;
			end else if (open_depth == 0) begin
				act = ACT_ENTER;
			end else if (open_depth >= NEST_DEPTH_DEF) begin
				act = ACT_EXIT;
			end else begin
				act = ($urandom_range(0, 1) == 0) ? ACT_ENTER : ACT_EXIT;
			end
			offer_event(act, slot, now, 1'b0, '0);
		end

		s_axis_tvalid <= 1'b0;
		while (report_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== nested_scope_cycle_profiler.f =====
design/nscp_pkg.sv
design/nscp_ctrl.sv
design/nscp_dp.sv
design/nested_scope_cycle_profiler.sv
tb/sv/tb.sv
